[design/tpmab_pkg.sv]
// ----------------------------------------------------------------------------
// tpmab_pkg
// Shared constants and types for the tick-paced moving average blinker.
// ----------------------------------------------------------------------------
package tpmab_pkg;

   localparam int WINDOW_LEN_DEF = 10;

   localparam int SAMPLE_W  = 8;
   localparam int COUNT_W   = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0] READ_RATE_RST  = 8'd7;
   localparam logic [COUNT_W-1:0] BLINK_RATE_RST = 8'd9;

   // register index, taken from paddr[2]
   localparam logic REG_READ_RATE  = 1'b0;
   localparam logic REG_BLINK_RATE = 1'b1;

   typedef struct packed {
      logic blink;
      logic took_reading;
   } tpmab_flags_type;

endpackage

[design/tpmab_win_mem.sv]
// ----------------------------------------------------------------------------
// tpmab_win_mem
// Circular sample window in a synchronous memory. Presents the entry that
// the next write will overwrite (the oldest sample), zero if never written.
// ----------------------------------------------------------------------------
module tpmab_win_mem import tpmab_pkg::*; #(
   parameter int WindowLen = WINDOW_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [SAMPLE_W-1:0] wr_data,
   output logic [SAMPLE_W-1:0] oldest
);

   localparam int PtrW = $clog2(WindowLen);

   logic [SAMPLE_W-1:0]  mem [WindowLen];
   logic [WindowLen-1:0] valid_ff, valid_in;
   logic [PtrW-1:0]      ptr_ff, ptr_in;
   logic [SAMPLE_W-1:0]  rd_data_ff;
   logic                 rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (reset) begin
         ptr_in = '0;
      end else if (wr_en) begin
         valid_in[ptr_ff] = 1'b1;
         ptr_in = (ptr_ff == PtrW'(WindowLen - 1)) ? '0 : ptr_ff + 1'b1;
      end else begin
         ptr_in = ptr_ff;
      end
   end

   // read always follows the next write slot; it never equals the slot being written
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         ptr_ff      <= ptr_in;
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[ptr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[ptr_ff] <= wr_data;
      end
      rd_data_ff <= mem[ptr_in];
   end

   assign oldest = rd_valid_ff ? rd_data_ff : '0;

endmodule

[design/tpmab_avg_pipe.sv]
// ----------------------------------------------------------------------------
// tpmab_avg_pipe
// Pipelined divide of the window sum by the window length (reciprocal
// multiply plus one correction step) and the output register.
// ----------------------------------------------------------------------------
module tpmab_avg_pipe import tpmab_pkg::*; #(
   parameter int WindowLen = WINDOW_LEN_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [SAMPLE_W+$clog2(WindowLen)-1:0] in_sum,
   input  tpmab_flags_type                        in_flags,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [SAMPLE_W-1:0]                    rsp_average,
   output logic                                   rsp_blink,
   output logic                                   rsp_took_reading
);

   localparam int SumW  = SAMPLE_W + $clog2(WindowLen);
   localparam int ProdW = 2 * SumW;
   localparam logic [SumW-1:0] Recip = SumW'((1 << SumW) / WindowLen);
   localparam logic [SumW-1:0] LenC  = SumW'(WindowLen);

   logic                s0_v_ff, s1_v_ff, s2_v_ff, rsp_valid_ff;
   logic [SumW-1:0]     s0_sum_ff, s1_sum_ff, s2_sum_ff;
   tpmab_flags_type     s0_flags_ff, s1_flags_ff, s2_flags_ff, rsp_flags_ff;
   logic [ProdW-1:0]    s1_prod_ff;
   logic [SumW-1:0]     s2_quot_ff;
   logic [SAMPLE_W-1:0] rsp_average_ff;

   logic            out_ready, r2, r1, r0;
   logic [SumW-1:0] rem, quot_fix;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign r2        = !s2_v_ff || out_ready;
   assign r1        = !s1_v_ff || r2;
   assign r0        = !s0_v_ff || r1;
   assign in_ready  = r0;

   // estimate is exact or one low; correct with one compare and subtract
   assign rem      = s2_sum_ff - SumW'(s2_quot_ff * LenC);
   assign quot_fix = (rem >= LenC) ? s2_quot_ff + 1'b1 : s2_quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff      <= 1'b0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (r0) begin
            s0_v_ff <= in_valid;
         end
         if (r1) begin
            s1_v_ff <= s0_v_ff;
         end
         if (r2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= s2_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (r0) begin
         s0_sum_ff   <= in_sum;
         s0_flags_ff <= in_flags;
      end
      if (r1) begin
         s1_prod_ff  <= ProdW'(s0_sum_ff) * ProdW'(Recip);
         s1_sum_ff   <= s0_sum_ff;
         s1_flags_ff <= s0_flags_ff;
      end
      if (r2) begin
         s2_quot_ff  <= s1_prod_ff[ProdW-1:SumW];
         s2_sum_ff   <= s1_sum_ff;
         s2_flags_ff <= s1_flags_ff;
      end
      if (out_ready) begin
         rsp_average_ff <= quot_fix[SAMPLE_W-1:0];
         rsp_flags_ff   <= s2_flags_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_average      = rsp_average_ff;
   assign rsp_blink        = rsp_flags_ff.blink;
   assign rsp_took_reading = rsp_flags_ff.took_reading;

endmodule

[design/tick_paced_moving_average_blinker_top.sv]
// ----------------------------------------------------------------------------
// tick_paced_moving_average_blinker_top
// Tick-paced moving average of an 8-bit sample with a blink flag.
// ----------------------------------------------------------------------------
// Each req_ transfer is one timer tick carrying req_sample. Every
// read_rate+1 ticks the sample goes into a WindowLen-deep window and the
// average becomes floor(window sum / WindowLen); between readings the last
// average is repeated. The blink flag toggles every blink_rate+1 readings.
// Every tick yields exactly one rsp_ transfer, in order.
// Throughput: one tick per cycle. The window lives in a memory with one
// write and one read per cycle; the read fetches the oldest sample ahead of
// time and a running sum is updated with it, so back-to-back readings work.
// The result passes the three stages of the reciprocal divide and then
// the output register before rsp_valid rises.
// When rsp_stall is high the output holds; the earlier stages keep filling,
// and req_stall rises only once every stage is full.
// Reset clears counters, blink flag, sum and the window (valid bits), and
// loads read_rate = 7, blink_rate = 9. Registers: read_rate at 0x0,
// blink_rate at 0x4; write them only while the block is idle.
// ----------------------------------------------------------------------------
module tick_paced_moving_average_blinker_top import tpmab_pkg::*; #(
   parameter int WindowLen = WINDOW_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SAMPLE_W-1:0]   req_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SAMPLE_W-1:0]   rsp_average,
   output logic                  rsp_blink,
   output logic                  rsp_took_reading,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int SumW = SAMPLE_W + $clog2(WindowLen);

   logic [COUNT_W-1:0]  read_rate_ff, blink_rate_ff;
   logic [COUNT_W-1:0]  tick_count_ff, tick_count_in;
   logic [COUNT_W-1:0]  reading_count_ff, reading_count_in;
   logic                blink_ff, blink_in;
   logic [SumW-1:0]     sum_ff, sum_in;

   logic                pipe_ready, accept, reading, csr_write;
   logic                reg_sel;
   logic [SAMPLE_W-1:0] oldest;
   tpmab_flags_type     flags;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign reg_sel   = paddr[2];

   always_comb begin
      unique case (reg_sel)
         REG_READ_RATE:  prdata = CSR_DATA_W'(read_rate_ff);
         REG_BLINK_RATE: prdata = CSR_DATA_W'(blink_rate_ff);
         default:        prdata = '0;
      endcase
   end

   assign req_stall = !pipe_ready;
   assign accept    = req_valid && pipe_ready;
   assign reading   = tick_count_ff == read_rate_ff;

   always_comb begin
      tick_count_in    = tick_count_ff;
      reading_count_in = reading_count_ff;
      blink_in         = blink_ff;
      sum_in           = sum_ff;
      if (accept) begin
         if (reading) begin
            tick_count_in = '0;
            // drop the oldest sample, add the new one
            sum_in = sum_ff + SumW'(req_sample) - SumW'(oldest);
            if (reading_count_ff == blink_rate_ff) begin
               blink_in         = !blink_ff;
               reading_count_in = '0;
            end else begin
               reading_count_in = reading_count_ff + 1'b1;
            end
         end else begin
            tick_count_in = tick_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_rate_ff     <= READ_RATE_RST;
         blink_rate_ff    <= BLINK_RATE_RST;
         tick_count_ff    <= '0;
         reading_count_ff <= '0;
         blink_ff         <= 1'b0;
         sum_ff           <= '0;
      end else begin
         if (csr_write && pready) begin
            unique case (reg_sel)
               REG_READ_RATE:  read_rate_ff  <= pwdata[COUNT_W-1:0];
               REG_BLINK_RATE: blink_rate_ff <= pwdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         tick_count_ff    <= tick_count_in;
         reading_count_ff <= reading_count_in;
         blink_ff         <= blink_in;
         sum_ff           <= sum_in;
      end
   end

   assign flags.blink        = blink_in;
   assign flags.took_reading = reading;

   tpmab_win_mem #(
      .WindowLen(WindowLen)
   ) u_win_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && reading),
      .wr_data (req_sample),
      .oldest  (oldest)
   );

   tpmab_avg_pipe #(
      .WindowLen(WindowLen)
   ) u_avg_pipe (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_valid),
      .in_ready         (pipe_ready),
      .in_sum           (sum_in),
      .in_flags         (flags),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_average      (rsp_average),
      .rsp_blink        (rsp_blink),
      .rsp_took_reading (rsp_took_reading)
   );

endmodule

[tb/tick_paced_moving_average_blinker_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tick_paced_moving_average_blinker_top_test
// Self-checking test of the tick-paced moving average blinker.
// ----------------------------------------------------------------------------
// Drives timer ticks with samples through the req_ channel and keeps a
// cycle-free model of the tick counter, reading counter, sample window,
// held average and blink flag. Every accepted tick queues one predicted
// result; each rsp_ transfer is checked field by field against the oldest.
// Runs directed extremes, counter wraparound after lowering a rate, random
// rate settings with random idling on both sides, a long receiver hold-off
// and a final full-rate stretch. Registers are checked by reading them back.
// ----------------------------------------------------------------------------
module tick_paced_moving_average_blinker_top_test;
   import tpmab_pkg::*;

   localparam int WIN_DEPTH     = WINDOW_LEN_DEF;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [SAMPLE_W-1:0] average;
      logic                blink;
      logic                took_reading;
   } tick_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [SAMPLE_W-1:0]   req_sample;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [SAMPLE_W-1:0]   rsp_average;
   logic                  rsp_blink;
   logic                  rsp_took_reading;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   tick_result_type expected_results[$];

   // averaging model state and register copies
   logic [COUNT_W-1:0]  read_rate_q;
   logic [COUNT_W-1:0]  blink_rate_q;
   logic [COUNT_W-1:0]  tick_cnt;
   logic [COUNT_W-1:0]  reading_cnt;
   logic [SAMPLE_W-1:0] sample_win [WIN_DEPTH];
   logic                blink_q;
   logic [SAMPLE_W-1:0] avg_q;

   int  errors;
   int  n_ticks;
   int  n_readings;
   int  n_toggles;
   int  n_writes;
   bit  send_idle_en;
   bit  rsp_idle_en;
   int  hold_len;

   tick_paced_moving_average_blinker_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_average      (rsp_average),
      .rsp_blink        (rsp_blink),
      .rsp_took_reading (rsp_took_reading),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the model by one tick and return the result it produces.
   function automatic tick_result_type advance_average(input logic [SAMPLE_W-1:0] s);
      tick_result_type r;
      int              sum;
      int              i;
      r.took_reading = 1'b0;
      if (tick_cnt == read_rate_q) begin
         r.took_reading = 1'b1;
         tick_cnt = '0;
         n_readings++;
         if (reading_cnt == blink_rate_q) begin
            blink_q = ~blink_q;
            reading_cnt = '0;
            n_toggles++;
         end else begin
            reading_cnt = reading_cnt + 1'b1;
         end
         for (i = WIN_DEPTH - 1; i > 0; i--) sample_win[i] = sample_win[i-1];
         sample_win[0] = s;
         sum = 0;
         for (i = 0; i < WIN_DEPTH; i++) sum += sample_win[i];
         avg_q = SAMPLE_W'(sum / WIN_DEPTH);
      end else begin
         tick_cnt = tick_cnt + 1'b1;
      end
      r.average = avg_q;
      r.blink   = blink_q;
      return r;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      unique case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return SAMPLE_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Offer one tick and hold it until the transfer; valid stays high after unless random idling drops it.
   task automatic send_tick(input logic [SAMPLE_W-1:0] s);
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      expected_results.push_back(advance_average(s));
      n_ticks++;
      if (send_idle_en && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic send_random_ticks(input int count);
      repeat (count) send_tick(pick_sample());
   endtask

   // Stop offering and wait until every predicted result has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apb_xfer(input logic wr, input logic idx,
                           input logic [CSR_DATA_W-1:0] wdata,
                           output logic [CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      // leave the bus idle between transfers
      @(posedge clock);
   endtask

   task automatic check_reg(input logic idx, input logic [COUNT_W-1:0] want);
      logic [CSR_DATA_W-1:0] got;
      apb_xfer(1'b0, idx, '0, got);
      if (got[COUNT_W-1:0] !== want) begin
         $error("register %0d readback: expected %0d, got %0d", idx, want,
                got[COUNT_W-1:0]);
         errors++;
      end
   endtask

   task automatic cfg_write(input logic idx, input logic [COUNT_W-1:0] value);
      logic [CSR_DATA_W-1:0] unused;
      // junk in the upper bits must be dropped by the register
      apb_xfer(1'b1, idx, {CSR_DATA_W'($urandom)} & ~CSR_DATA_W'(8'hff) | value,
               unused);
      if (idx == REG_READ_RATE) read_rate_q = value;
      else                      blink_rate_q = value;
      n_writes++;
      check_reg(idx, value);
   endtask

   task automatic set_rates(input logic [COUNT_W-1:0] rr, input logic [COUNT_W-1:0] br);
      cfg_write(REG_READ_RATE, rr);
      cfg_write(REG_BLINK_RATE, br);
   endtask

   task automatic test_defaults();
      check_reg(REG_READ_RATE, READ_RATE_RST);
      check_reg(REG_BLINK_RATE, BLINK_RATE_RST);
      for (int i = 0; i < 8; i++) send_tick(i[0] ? 8'h00 : 8'hff);
      drain();
   endtask

   task automatic test_extremes();
      set_rates(8'd0, 8'd0);
      // fill the window with the top value, then feed it mixed values
      repeat (WIN_DEPTH) send_tick(8'hff);
      send_tick(8'h55);
      send_tick(8'haa);
      send_tick(8'h00);
      send_tick(8'h01);
      send_tick(8'hfe);
      drain();
   endtask

   task automatic test_count_wrap();
      send_idle_en = 1'b1;
      rsp_idle_en  = 1'b1;
      // lower read_rate under the tick count: count wraps past 255
      set_rates(8'd100, 8'd255);
      send_random_ticks(40);
      drain();
      cfg_write(REG_READ_RATE, 8'd10);
      send_random_ticks(230);
      drain();
      // same for blink_rate under the reading count
      set_rates(8'd0, 8'd200);
      send_random_ticks(30);
      drain();
      cfg_write(REG_BLINK_RATE, 8'd4);
      send_random_ticks(230);
      drain();
   endtask

   task automatic test_random_settings();
      logic [COUNT_W-1:0] rr;
      logic [COUNT_W-1:0] br;
      int                 count;
      send_idle_en = 1'b1;
      rsp_idle_en  = 1'b1;
      for (int p = 0; p < 6; p++) begin
         count = 80;
         unique case (p)
            0: begin rr = 8'd0;   br = 8'd0;   end
            1: begin rr = 8'd2;   br = 8'd255; end
            2: begin rr = 8'd255; br = 8'd1; count = 280; end
            3: begin rr = 8'd1;   br = 8'd7;   end
            default: begin
               rr = COUNT_W'($urandom_range(0, 15));
               br = COUNT_W'($urandom_range(0, 15));
            end
         endcase
         set_rates(rr, br);
         send_random_ticks(count);
         drain();
      end
   endtask

   task automatic test_backpressure();
      send_idle_en = 1'b0;
      rsp_idle_en  = 1'b0;
      set_rates(8'd1, 8'd2);
      // receiver holds off long enough to fill the pipe and stall the sender
      hold_len = 80;
      send_random_ticks(40);
      drain();
      send_random_ticks(20);
      drain();
   endtask

   task automatic test_full_rate();
      send_idle_en = 1'b0;
      rsp_idle_en  = 1'b0;
      set_rates(8'd3, 8'd1);
      send_random_ticks(150);
      drain();
   endtask

   // receiver side: random stall bursts, or one long hold when asked
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_len) @(posedge clock);
            hold_len = 0;
            rsp_stall <= 1'b0;
         end else if (rsp_idle_en && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_results
      tick_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected: average %0d", rsp_average);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_average !== want.average) begin
               $error("average: expected %0d, got %0d", want.average, rsp_average);
               errors++;
            end
            if (rsp_blink !== want.blink) begin
               $error("blink: expected %0d, got %0d", want.blink, rsp_blink);
               errors++;
            end
            if (rsp_took_reading !== want.took_reading) begin
               $error("took_reading: expected %0d, got %0d", want.took_reading,
                      rsp_took_reading);
               errors++;
            end
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results outstanding", cycles,
                   expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_sample   = '0;
      rsp_stall    = 1'b0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      errors       = 0;
      n_ticks      = 0;
      n_readings   = 0;
      n_toggles    = 0;
      n_writes     = 0;
      send_idle_en = 1'b0;
      rsp_idle_en  = 1'b0;
      hold_len     = 0;
      read_rate_q  = READ_RATE_RST;
      blink_rate_q = BLINK_RATE_RST;
      tick_cnt     = '0;
      reading_cnt  = '0;
      blink_q      = 1'b0;
      avg_q        = '0;
      foreach (sample_win[i]) sample_win[i] = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_defaults();
      test_extremes();
      test_count_wrap();
      test_random_settings();
      test_backpressure();
      test_full_rate();
      drain();

      $display("Run covered %0d ticks, %0d readings and %0d blink toggles", n_ticks,
               n_readings, n_toggles);
      $display("over %0d register writes, with random idling and a long hold-off",
               n_writes);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
